>>> design/rzme_pkg.sv
// ----------------------------------------------------------------------------
// rzme_pkg
// shared types and constants of the radial zone mask evaluator
// ----------------------------------------------------------------------------
package rzme_pkg;

  localparam int          MAX_ENTRIES_DEF = 32;
  localparam logic [15:0] ONE_Q15         = 16'd32768;
  localparam logic        FUNC_ADD        = 1'b0;
  localparam logic        FUNC_EVAL       = 1'b1;

  // one stored inclusion circle
  typedef struct packed {
    logic [15:0]        weight;
    logic signed [31:0] center_x;
    logic signed [31:0] center_z;
    logic [30:0]        soft_rad;
    logic [30:0]        hard;
  } circle_t;

  // status of the influence unit toward the sequencer
  typedef struct packed {
    logic        done;
    logic [15:0] value;
  } infl_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_READ,
    T_LAUNCH,
    T_RUN
  } top_state_t;

  typedef enum logic [3:0] {
    U_IDLE,
    U_DIFF,
    U_SQX,
    U_SQZ,
    U_SQRT,
    U_CMP,
    U_DIV,
    U_DONE
  } unit_state_t;

  // clamp a q1.15 value to 1.0
  function automatic logic [15:0] sat_q15(input logic [15:0] v);
    sat_q15 = (v > ONE_Q15) ? ONE_Q15 : v;
  endfunction

endpackage

>>> design/rzme_infl_unit.sv
// ----------------------------------------------------------------------------
// rzme_infl_unit
// influence of one circle on a point: distance, bit-serial square root, ramp
// ----------------------------------------------------------------------------
module rzme_infl_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  rzme_pkg::circle_t  circle,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_z,
  output rzme_pkg::infl_t    status
);

  rzme_pkg::unit_state_t state_r, state_nxt;

  rzme_pkg::circle_t  circ_r;
  logic signed [31:0] px_r;
  logic signed [31:0] pz_r;
  logic [30:0]        ax_r;
  logic [30:0]        az_r;
  logic [61:0]        sq_r;
  logic [63:0]        rad_r;
  logic [33:0]        rem_r;
  logic [31:0]        root_r;
  logic [4:0]         cnt_r;
  logic [46:0]        prod_r;
  logic [30:0]        den_r;
  logic [15:0]        q_r;
  logic [15:0]        val_r;

  logic signed [32:0] dx;
  logic signed [32:0] dz;
  logic [32:0]        ax;
  logic [32:0]        az;
  logic               far;
  logic [35:0]        rem_t;
  logic [35:0]        trial;
  logic               sq_bit;
  logic [46:0]        dsh;
  logic               q_bit;
  logic               r_above_hard;
  logic               r_below_soft;
  logic               no_ramp;
  logic               last_step;

  always_comb begin
    dx           = 33'(px_r) - 33'(circ_r.center_x);
    dz           = 33'(pz_r) - 33'(circ_r.center_z);
    ax           = dx[32] ? 33'(-dx) : 33'(dx);
    az           = dz[32] ? 33'(-dz) : 33'(dz);
    far          = (ax > 33'(circ_r.hard)) || (az > 33'(circ_r.hard));
    rem_t        = {rem_r, rad_r[63:62]};
    trial        = {2'b00, root_r, 2'b01};
    sq_bit       = (rem_t >= trial);
    dsh          = 47'(den_r) << cnt_r[3:0];
    q_bit        = (prod_r >= dsh);
    r_above_hard = (root_r > 32'(circ_r.hard));
    r_below_soft = (root_r < 32'(circ_r.soft_rad));
    no_ramp      = (circ_r.hard <= circ_r.soft_rad);
    last_step    = (cnt_r == '0);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rzme_pkg::U_IDLE: if (start) state_nxt = rzme_pkg::U_DIFF;
      rzme_pkg::U_DIFF: state_nxt = far ? rzme_pkg::U_DONE : rzme_pkg::U_SQX;
      rzme_pkg::U_SQX:  state_nxt = rzme_pkg::U_SQZ;
      rzme_pkg::U_SQZ:  state_nxt = rzme_pkg::U_SQRT;
      rzme_pkg::U_SQRT: if (cnt_r == 5'd31) state_nxt = rzme_pkg::U_CMP;
      rzme_pkg::U_CMP: begin
        if (r_above_hard || r_below_soft || no_ramp) state_nxt = rzme_pkg::U_DONE;
        else state_nxt = rzme_pkg::U_DIV;
      end
      rzme_pkg::U_DIV:  if (last_step) state_nxt = rzme_pkg::U_DONE;
      rzme_pkg::U_DONE: state_nxt = rzme_pkg::U_IDLE;
      default:          state_nxt = rzme_pkg::U_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    status.done  = (state_r == rzme_pkg::U_DONE);
    status.value = val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rzme_pkg::U_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      rzme_pkg::U_IDLE: begin
        circ_r <= circle;
        px_r   <= point_x;
        pz_r   <= point_z;
      end
      rzme_pkg::U_DIFF: begin
        ax_r  <= ax[30:0];
        az_r  <= az[30:0];
        val_r <= '0;
      end
      rzme_pkg::U_SQX: begin
        sq_r <= 62'(ax_r) * 62'(ax_r);
      end
      rzme_pkg::U_SQZ: begin
        rad_r  <= 64'(sq_r) + 64'(62'(az_r) * 62'(az_r));
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
      end
      rzme_pkg::U_SQRT: begin
        // one root bit per cycle
        rad_r  <= {rad_r[61:0], 2'b00};
        rem_r  <= sq_bit ? 34'(rem_t - trial) : rem_t[33:0];
        root_r <= {root_r[30:0], sq_bit};
        cnt_r  <= cnt_r + 5'd1;
      end
      rzme_pkg::U_CMP: begin
        if (r_above_hard) val_r <= '0;
        else if (r_below_soft) val_r <= circ_r.weight;
        else val_r <= '0;
        prod_r <= 47'(circ_r.weight) * 47'(circ_r.hard - root_r[30:0]);
        den_r  <= circ_r.hard - circ_r.soft_rad;
        q_r    <= '0;
        cnt_r  <= 5'd15;
      end
      rzme_pkg::U_DIV: begin
        // restoring division, quotient never exceeds the weight
        if (q_bit) prod_r <= prod_r - dsh;
        q_r   <= {q_r[14:0], q_bit};
        cnt_r <= cnt_r - 5'd1;
        if (last_step) val_r <= {q_r[14:0], q_bit};
      end
      default: begin
      end
    endcase
  end

endmodule

>>> design/radial_zone_mask_evaluator.sv
// ----------------------------------------------------------------------------
// radial_zone_mask_evaluator
// table of inclusion circles and max-influence evaluation of a point
// ----------------------------------------------------------------------------
// An add transaction is taken while busy is low and its result strobes in the
// cycle after; busy stays low, so adds may follow back to back. An evaluate
// transaction on an empty table also finishes that way. Otherwise busy rises
// and the circles are walked one at a time from the circle memory: each goes
// through a read state and a launch state, then the influence unit runs its
// control states plus 32 square root steps and, on the ramp, 16 divide steps
// (a point far outside the circle skips both). Busy stays high until the last
// circle is done and the result strobes in the first cycle with busy low
// again, so the number of stored circles sets the evaluation time. The result
// strobes for exactly one cycle on out_strobe and must be taken then: the
// receiver cannot stall the block. No clearing pass is needed after reset,
// since only written entries are read.
module radial_zone_mask_evaluator #(
  parameter int MAX_ENTRIES = rzme_pkg::MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_func,
  input  logic [15:0]        in_circle_weight,
  input  logic signed [31:0] in_circle_center_x,
  input  logic signed [31:0] in_circle_center_z,
  input  logic [30:0]        in_soft_radius,
  input  logic [30:0]        in_hard_radius,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_z,
  input  logic [15:0]        in_height_factor,
  input  logic [15:0]        in_slope_factor,
  output logic               out_strobe,
  output logic [15:0]        out_zone_value,
  output logic               out_table_full,
  output logic [5:0]         out_circle_count
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  rzme_pkg::top_state_t state_r, state_nxt;

  // circle memory, one entry per stored circle
  rzme_pkg::circle_t mem [MAX_ENTRIES];
  rzme_pkg::circle_t rd_data_r;

  logic [CNT_W-1:0]   count_r;
  logic [IDX_W-1:0]   idx_r;
  logic signed [31:0] px_r;
  logic signed [31:0] pz_r;
  logic [15:0]        hf_r;
  logic [15:0]        sf_r;
  logic [15:0]        circ_r;
  logic               strobe_r;
  logic [15:0]        value_r;
  logic               full_r;
  logic [5:0]         count_out_r;

  logic               accept;
  logic               is_add;
  logic               has_room;
  logic               unit_start;
  rzme_pkg::infl_t    unit_st;
  rzme_pkg::circle_t  new_circle;
  logic [15:0]        hf_sat;
  logic [15:0]        sf_sat;
  logic [15:0]        empty_val;
  logic [15:0]        cand;
  logic [15:0]        eval_val;
  logic               last_circle;

  always_comb begin
    accept              = start && !busy;
    is_add              = (in_func == rzme_pkg::FUNC_ADD);
    has_room            = (count_r < CNT_W'(MAX_ENTRIES));
    new_circle.weight   = rzme_pkg::sat_q15(in_circle_weight);
    new_circle.center_x = in_circle_center_x;
    new_circle.center_z = in_circle_center_z;
    new_circle.soft_rad = in_soft_radius;
    new_circle.hard     = in_hard_radius;
    hf_sat              = rzme_pkg::sat_q15(in_height_factor);
    sf_sat              = rzme_pkg::sat_q15(in_slope_factor);
    // empty table: min of 1.0 and the factors
    empty_val           = (hf_sat < sf_sat) ? hf_sat : sf_sat;
    // running max folded with the latest influence, then the factor clamp
    cand                = (unit_st.value > circ_r) ? unit_st.value : circ_r;
    eval_val            = cand;
    if (hf_r < eval_val) eval_val = hf_r;
    if (sf_r < eval_val) eval_val = sf_r;
    last_circle         = (CNT_W'(idx_r) == count_r - CNT_W'(1));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rzme_pkg::T_IDLE: begin
        if (accept && !is_add && (count_r != '0)) state_nxt = rzme_pkg::T_READ;
      end
      rzme_pkg::T_READ:   state_nxt = rzme_pkg::T_LAUNCH;
      rzme_pkg::T_LAUNCH: state_nxt = rzme_pkg::T_RUN;
      rzme_pkg::T_RUN: begin
        if (unit_st.done) state_nxt = last_circle ? rzme_pkg::T_IDLE : rzme_pkg::T_READ;
      end
      default: state_nxt = rzme_pkg::T_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    busy       = (state_r != rzme_pkg::T_IDLE);
    unit_start = (state_r == rzme_pkg::T_LAUNCH);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rzme_pkg::T_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= 1'b0;
      if (accept && is_add && has_room) count_r <= count_r + CNT_W'(1);
      if (accept && (is_add || (count_r == '0))) strobe_r <= 1'b1;
      if ((state_r == rzme_pkg::T_RUN) && unit_st.done && last_circle) strobe_r <= 1'b1;
    end
  end

  // circle memory write and registered read
  always_ff @(posedge clk) begin
    if (accept && is_add && has_room) mem[count_r[IDX_W-1:0]] <= new_circle;
    rd_data_r <= mem[idx_r];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      px_r   <= in_point_x;
      pz_r   <= in_point_z;
      hf_r   <= hf_sat;
      sf_r   <= sf_sat;
      circ_r <= '0;
      idx_r  <= '0;
      if (is_add) begin
        value_r     <= '0;
        full_r      <= !has_room;
        count_out_r <= has_room ? 6'(count_r + CNT_W'(1)) : 6'(count_r);
      end else begin
        value_r     <= empty_val;
        full_r      <= 1'b0;
        count_out_r <= 6'(count_r);
      end
    end
    if ((state_r == rzme_pkg::T_RUN) && unit_st.done) begin
      circ_r <= cand;
      idx_r  <= idx_r + IDX_W'(1);
      if (last_circle) value_r <= eval_val;
    end
  end

  rzme_infl_unit u_infl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (unit_start),
    .circle  (rd_data_r),
    .point_x (px_r),
    .point_z (pz_r),
    .status  (unit_st)
  );

  assign out_strobe       = strobe_r;
  assign out_zone_value   = value_r;
  assign out_table_full   = full_r;
  assign out_circle_count = count_out_r;

endmodule
